// ===== sv/dsv_pkg.sv =====
`default_nettype none

package dsv_pkg;

    // Character codes of the date text.
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Largest value a part can hold; passing it sets the overflow flag.
    localparam logic [30:0] VALUE_LIMIT = 31'h7FFF_FFFF;

    // Reset values of the year window.
    localparam logic [13:0] YEAR_MIN_RESET = 14'd2000;
    localparam logic [13:0] YEAR_MAX_RESET = 14'd2999;

    // Configuration register indexes.
    localparam logic CFG_YEAR_MIN = 1'b0;
    localparam logic CFG_YEAR_MAX = 1'b1;

    // Verdict codes.
    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_MISSING  = 4'd1,
        ERR_EXTRA    = 4'd2,
        ERR_EMPTY    = 4'd3,
        ERR_NONDIGIT = 4'd4,
        ERR_OVERFLOW = 4'd5,
        ERR_MONTH    = 4'd6,
        ERR_YEAR     = 4'd7,
        ERR_DAY      = 4'd8
    } t_err;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic [3:0]  error_code;
        logic [4:0]  day_value;
        logic [3:0]  month_value;
        logic [13:0] year_value;
    } t_out_beat;

    // Parser state; also the snapshot handed to the judge at end of text.
    typedef struct packed {
        logic [1:0]       slash_count;
        logic [2:0][30:0] values;
        logic [2:0]       empty;
        logic [2:0]       nondigit;
        logic [2:0]       overflow;
    } t_parts;

endpackage

`default_nettype wire

// ===== sv/dsv_accum.sv =====
`default_nettype none

module dsv_accum import dsv_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // Character from the input register.
    input  wire logic     i_valid,
    input  wire t_in_beat i_beat,
    output logic          o_take,
    // Snapshot of a finished text toward the judge.
    output logic          o_snap_valid,
    output t_parts        o_snap,
    input  wire logic     i_snap_ready
);

    t_parts r_state;
    t_parts n_state;
    t_parts r_snap;
    logic   r_snap_valid;
    logic   snap_ready;

    logic [1:0]  part;
    logic [3:0]  diff;
    logic [34:0] wide;
    logic [34:0] sum;

    localparam t_parts PARTS_RESET = '{
        slash_count: 2'd0,
        values:      '0,
        empty:       3'b111,
        nondigit:    3'b000,
        overflow:    3'b000
    };

    // A plain character always moves on; the last one needs a free snapshot slot.
    assign snap_ready = !r_snap_valid || i_snap_ready;
    assign o_take     = i_valid && (!i_beat.last_char || snap_ready);

    // Update of the current part for one character.
    // The low nibble of an ASCII digit is its value.
    always_comb begin
        n_state = r_state;
        part    = r_state.slash_count;
        diff    = i_beat.char_in[3:0];
        wide    = {4'b0, r_state.values[part]};
        sum     = (wide << 3) + (wide << 1) + {31'b0, diff};
        if (i_beat.char_in == CHAR_SLASH) begin
            if (r_state.slash_count != 2'd3) begin
                n_state.slash_count = r_state.slash_count + 2'd1;
            end
        end else if (r_state.slash_count != 2'd3) begin
            n_state.empty[part] = 1'b0;
            if (i_beat.char_in < CHAR_ZERO || i_beat.char_in > CHAR_NINE) begin
                n_state.nondigit[part] = 1'b1;
            end else if (sum > {4'b0, VALUE_LIMIT}) begin
                n_state.values[part]   = VALUE_LIMIT;
                n_state.overflow[part] = 1'b1;
            end else begin
                n_state.values[part] = sum[30:0];
            end
        end
    end

    // Parser state; it returns to its reset value after the last character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARTS_RESET;
        end else if (o_take) begin
            r_state <= i_beat.last_char ? PARTS_RESET : n_state;
        end
    end

    // Snapshot slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (snap_ready) begin
            r_snap_valid <= o_take && i_beat.last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_beat.last_char) begin
            r_snap <= n_state;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

// ===== sv/dsv_judge.sv =====
`default_nettype none

module dsv_judge import dsv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [13:0] i_year_min,
    input  wire logic [13:0] i_year_max,
    // Snapshot from the parser.
    input  wire logic        i_snap_valid,
    input  wire t_parts      i_snap,
    output logic             o_snap_ready,
    // Result beat.
    output logic             o_valid,
    output t_out_beat        o_data,
    input  wire logic        i_stall
);

    // Intermediate verdict between the two judging stages.
    typedef struct packed {
        t_err        code;
        logic        day_big;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [7:0]  century;
    } t_mid;

    t_mid      r_mid;
    t_mid      n_mid;
    logic      r_mid_valid;
    t_out_beat r_out;
    t_out_beat n_out;
    logic      r_out_valid;
    logic      out_ready;
    logic      mid_ready;

    logic [30:0] day_full;
    logic [30:0] month_full;
    logic [30:0] year_full;
    logic [26:0] recip;

    logic [13:0] century_base;
    logic        leap;
    logic [4:0]  month_len;

    // Days in a month; zero for a month that does not exist.
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic is_leap);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = is_leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    assign out_ready    = !r_out_valid || !i_stall;
    assign mid_ready    = !r_mid_valid || out_ready;
    assign o_snap_ready = mid_ready;

    // First stage: format checks in priority order, month and year ranges,
    // and year / 100 by a reciprocal multiply (exact for 14-bit years).
    always_comb begin
        day_full   = i_snap.values[0];
        month_full = i_snap.values[1];
        year_full  = i_snap.values[2];
        recip      = year_full[13:0] * 13'd5243;

        n_mid.day_big = day_full > 31'd31;
        n_mid.day     = day_full[4:0];
        n_mid.month   = month_full[3:0];
        n_mid.year    = year_full[13:0];
        n_mid.century = recip[26:19];

        if (i_snap.slash_count < 2'd2) begin
            n_mid.code = ERR_MISSING;
        end else if (i_snap.slash_count == 2'd3) begin
            n_mid.code = ERR_EXTRA;
        end else if (i_snap.empty[0]) begin
            n_mid.code = ERR_EMPTY;
        end else if (i_snap.nondigit[0]) begin
            n_mid.code = ERR_NONDIGIT;
        end else if (i_snap.empty[1]) begin
            n_mid.code = ERR_EMPTY;
        end else if (i_snap.nondigit[1]) begin
            n_mid.code = ERR_NONDIGIT;
        end else if (i_snap.empty[2]) begin
            n_mid.code = ERR_EMPTY;
        end else if (i_snap.nondigit[2]) begin
            n_mid.code = ERR_NONDIGIT;
        end else if (|i_snap.overflow) begin
            n_mid.code = ERR_OVERFLOW;
        end else if (month_full < 31'd1 || month_full > 31'd12) begin
            n_mid.code = ERR_MONTH;
        end else if (year_full < {17'b0, i_year_min} || year_full > {17'b0, i_year_max}) begin
            n_mid.code = ERR_YEAR;
        end else begin
            n_mid.code = ERR_OK;
        end
    end

    // Second stage: leap year, month length and the day check.
    always_comb begin
        century_base = {6'b0, r_mid.century} * 14'd100;
        if (r_mid.year == century_base) begin
            leap = r_mid.century[1:0] == 2'b00;
        end else begin
            leap = r_mid.year[1:0] == 2'b00;
        end
        month_len = month_days(r_mid.month, leap);

        n_out = '0;
        if (r_mid.code != ERR_OK) begin
            n_out.error_code = r_mid.code;
        end else if (r_mid.day_big || r_mid.day == 5'd0 || r_mid.day > month_len) begin
            n_out.error_code = ERR_DAY;
        end else begin
            n_out.error_code  = ERR_OK;
            n_out.day_value   = r_mid.day;
            n_out.month_value = r_mid.month;
            n_out.year_value  = r_mid.year;
        end
    end

    // Stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mid_ready) begin
                r_mid_valid <= i_snap_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (mid_ready && i_snap_valid) begin
            r_mid <= n_mid;
        end
        if (out_ready && r_mid_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ===== sv/date_string_validator.sv =====
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+----------------------------------
// input    | in        | i_valid / o_stall   | i_data : t_in_beat (char, last)
// result   | out       | o_valid / i_stall   | o_data : t_out_beat (code, date)
// config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// One character beat is taken every cycle unless a text's last character waits
// for a free snapshot slot. A result beat passes the input register, parser
// with snapshot, and two judging stages ending in the output register.
// Reset (synchronous, active low) clears the parser and sets the year window
// to 2000..2999. A stalled result only holds the pipeline behind it once all
// stages between the parser and the output are full.

module date_string_validator import dsv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_beat    i_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_beat        o_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);

    t_in_beat    r_in;
    logic        r_in_valid;
    logic        in_take;
    logic [13:0] r_year_min;
    logic [13:0] r_year_max;

    logic   snap_valid;
    logic   snap_ready;
    t_parts snap;

    // Input register frees up whenever the parser takes its beat.
    assign o_stall = r_in_valid && !in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
    end

    // Year window registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year_min <= YEAR_MIN_RESET;
            r_year_max <= YEAR_MAX_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_YEAR_MIN) begin
                r_year_min <= i_cfg_data;
            end
            if (i_cfg_index == CFG_YEAR_MAX) begin
                r_year_max <= i_cfg_data;
            end
        end
    end

    dsv_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_beat       (r_in),
        .o_take       (in_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap),
        .i_snap_ready (snap_ready)
    );

    dsv_judge u_judge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_year_min   (r_year_min),
        .i_year_max   (r_year_max),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_ready (snap_ready),
        .o_valid      (o_valid),
        .o_data       (o_data),
        .i_stall      (i_stall)
    );

endmodule

`default_nettype wire

// ===== tb/date_string_validator_tb.sv =====
`timescale 1ns / 1ps

module date_string_validator_tb;
    import dsv_pkg::*;

    localparam int  CLK_HALF     = 5;
    localparam int  RESET_CYCLES = 12;
    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_CHARS  = 180;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  NUM_ROWS     = 24;
    // In the directed rows this character stands for the zero byte.
    localparam byte ZERO_BYTE_MARK = "#";

    // One character beat waiting to be sent, with an optional typed verdict.
    typedef struct {
        t_in_beat  beat;
        bit        fixed;
        t_out_beat fixed_res;
    } char_beat_t;

    typedef struct {
        string       text;
        bit          fixed;
        t_err        code;
        int unsigned d;
        int unsigned m;
        int unsigned y;
    } date_row_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_in_beat    i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_out_beat   o_data;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data  = '0;

    date_string_validator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Stimulus and expectation stores.
    char_beat_t  char_q [$];
    char_beat_t  cur_char;
    t_out_beat   verdict_q [$];
    logic [7:0]  text_buf [$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          beats_queued   = 0;
    int          beats_taken    = 0;
    int          phase_chars    = 0;
    int          verdicts_checked = 0;
    int          mismatches     = 0;
    int          cycle_count    = 0;
    int          hold_asked     = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;
    int          code_tally [9];
    int          cfg_lo         = 2000;
    int          cfg_hi         = 2999;
    bit          in_taken       = 1'b0;

    date_row_t   date_rows [NUM_ROWS];

    // Predictor state: parser of the date text and the year window.
    logic [1:0]  pr_slashes;
    logic [30:0] pr_value [3];
    logic [2:0]  pr_empty;
    logic [2:0]  pr_nondigit;
    logic [2:0]  pr_overflow;
    logic [13:0] pr_year_lo;
    logic [13:0] pr_year_hi;

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    task clear_parser();
        int i;
        pr_slashes = 2'd0;
        for (i = 0; i < 3; i++) pr_value[i] = '0;
        pr_empty    = 3'b111;
        pr_nondigit = 3'b000;
        pr_overflow = 3'b000;
    endtask

    // Verdict on the parsed text, in the block's order of priority.
    function t_err judge_date();
        int          i;
        int unsigned d, m, y;
        if (pr_slashes < 2'd2) return ERR_MISSING;
        if (pr_slashes > 2'd2) return ERR_EXTRA;
        for (i = 0; i < 3; i++) begin
            if (pr_empty[i])    return ERR_EMPTY;
            if (pr_nondigit[i]) return ERR_NONDIGIT;
        end
        for (i = 0; i < 3; i++)
            if (pr_overflow[i]) return ERR_OVERFLOW;
        d = {1'b0, pr_value[0]};
        m = {1'b0, pr_value[1]};
        y = {1'b0, pr_value[2]};
        if (m < 1 || m > 12) return ERR_MONTH;
        if (y < pr_year_lo || y > pr_year_hi) return ERR_YEAR;
        if (d < 1 || d > days_in_month(m, y)) return ERR_DAY;
        return ERR_OK;
    endfunction

    // Folds one character into the parser; on the last one yields the verdict.
    task parse_date_char(input t_in_beat b, output bit done, output t_out_beat res);
        int unsigned dg, v, p;
        t_err        code;
        done = 1'b0;
        res  = '0;
        if (b.char_in == CHAR_SLASH) begin
            if (pr_slashes != 2'd3) pr_slashes = pr_slashes + 2'd1;
        end else if (pr_slashes != 2'd3) begin
            // Characters after a third slash leave every part alone.
            p = {30'b0, pr_slashes};
            pr_empty[p] = 1'b0;
            if (b.char_in < CHAR_ZERO || b.char_in > CHAR_NINE) begin
                pr_nondigit[p] = 1'b1;
            end else begin
                dg = {28'b0, b.char_in[3:0]};
                v  = {1'b0, pr_value[p]};
                if (v > (VALUE_LIMIT - dg) / 10) begin
                    pr_value[p]    = VALUE_LIMIT;
                    pr_overflow[p] = 1'b1;
                end else begin
                    pr_value[p] = 31'(v * 10 + dg);
                end
            end
        end
        if (b.last_char) begin
            code = judge_date();
            res.error_code = code;
            if (code == ERR_OK) begin
                res.day_value   = pr_value[0][4:0];
                res.month_value = pr_value[1][3:0];
                res.year_value  = pr_value[2][13:0];
            end
            done = 1'b1;
            clear_parser();
        end
    endtask

    task check_verdict(input t_out_beat got);
        t_out_beat want;
        if (got.error_code <= ERR_DAY) code_tally[got.error_code]++;
        if (verdict_q.size() == 0) begin
            mismatches++;
            $error("verdict beat with no pending expectation: error_code %0d",
                   got.error_code);
        end else begin
            want = verdict_q.pop_front();
            verdicts_checked++;
            if (got.error_code !== want.error_code) begin
                mismatches++;
                $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            end
            if (got.day_value !== want.day_value) begin
                mismatches++;
                $error("day_value: expected %0d, got %0d", want.day_value, got.day_value);
            end
            if (got.month_value !== want.month_value) begin
                mismatches++;
                $error("month_value: expected %0d, got %0d",
                       want.month_value, got.month_value);
            end
            if (got.year_value !== want.year_value) begin
                mismatches++;
                $error("year_value: expected %0d, got %0d", want.year_value, got.year_value);
            end
        end
    endtask

    // Sample everything at the rising edge: config writes, verdicts, input beats.
    always @(posedge i_clk) begin : monitor
        bit        done;
        t_out_beat res;
        in_taken = 1'b0;
        if (!i_rst_n) begin
            pr_year_lo = YEAR_MIN_RESET;
            pr_year_hi = YEAR_MAX_RESET;
            clear_parser();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_YEAR_MIN) pr_year_lo = i_cfg_data;
                else                             pr_year_hi = i_cfg_data;
            end
            if (o_valid && !i_stall) check_verdict(o_data);
            if (i_valid && !o_stall) begin
                in_taken = 1'b1;
                beats_taken++;
                parse_date_char(cur_char.beat, done, res);
                if (done) verdict_q.push_back(cur_char.fixed ? cur_char.fixed_res : res);
            end
        end
    end

    // Sender: a beat stays on the bus until it is taken.
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (char_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_char = char_q.pop_front();
                i_valid <= 1'b1;
                i_data  <= cur_char.beat;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, forced high while a long hold-off runs.
    always @(negedge i_clk) begin
        i_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Long hold-off of the receiver, counted here in cycles.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Moves the text in text_buf into the send queue, flagging its last beat.
    task push_text(input bit fixed, input t_out_beat res);
        char_beat_t item;
        int         i;
        for (i = 0; i < text_buf.size(); i++) begin
            item.beat.char_in   = text_buf[i];
            item.beat.last_char = (i == text_buf.size() - 1);
            item.fixed          = fixed && item.beat.last_char;
            item.fixed_res      = res;
            char_q.push_back(item);
            beats_queued++;
            phase_chars++;
        end
        text_buf.delete();
    endtask

    task automatic put_number(int unsigned v);
        string s;
        int    i;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) text_buf.push_back(CHAR_ZERO);
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // A part too large for the accumulator, or right at its limit.
    task automatic put_huge();
        string s;
        int    i;
        if ($urandom_range(0, 1) == 0) begin
            s = ($urandom_range(0, 1) == 0) ? "2147483647" : "2147483648";
            for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        end else begin
            text_buf.push_back(8'(CHAR_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(10, 11))
                text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
    endtask

    // One random text: mostly well-formed dates, some broken ones, some noise.
    task automatic add_random_text();
        int          kind, sel, r, huge_part, len, pos, n;
        int unsigned d, m, y;
        t_out_beat   none;
        none = '0;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 99) < 88) m = $urandom_range(1, 12);
            else m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);

            r = $urandom_range(0, 99);
            if (r < 55) begin
                y = (cfg_lo <= cfg_hi) ? $urandom_range(cfg_lo, cfg_hi) : $urandom_range(0, 9999);
            end else if (r < 75) begin
                case ($urandom_range(0, 3))
                    0:       y = (cfg_lo > 0) ? cfg_lo - 1 : 0;
                    1:       y = cfg_lo;
                    2:       y = cfg_hi;
                    default: y = cfg_hi + 1;
                endcase
            end else if (r < 90) begin
                y = $urandom_range(0, 9999);
            end else begin
                // Leap-year corners: centuries and plain multiples of four.
                y = ($urandom_range(0, 1) == 0) ? 100 * $urandom_range(0, 99)
                                                : 4 * $urandom_range(0, 2499);
                m = 2;
            end

            len = days_in_month(m, y);
            if (len == 0) len = 31;
            r = $urandom_range(0, 99);
            if (m == 2 && y % 4 == 0) d = $urandom_range(28, 30);
            else if (r < 80) d = $urandom_range(1, len);
            else if (r < 92) d = len + $urandom_range(0, 1);
            else d = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(32, 99);

            sel = $urandom_range(0, 3);
            huge_part = (kind >= 70 && sel == 0) ? $urandom_range(0, 2) : 3;
            if (huge_part == 0) put_huge(); else put_number(d);
            text_buf.push_back(CHAR_SLASH);
            if (huge_part == 1) put_huge(); else put_number(m);
            text_buf.push_back(CHAR_SLASH);
            if (huge_part == 2) put_huge(); else put_number(y);

            if (kind >= 70) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case (sel)
                    1: text_buf.insert(pos, CHAR_SLASH);
                    2: text_buf.delete(pos);
                    3: text_buf.insert(pos, 8'($urandom_range(0, 255)));
                    default: ;
                endcase
            end
        end else begin
            n = $urandom_range(1, 10);
            repeat (n) begin
                r = $urandom_range(0, 9);
                if (r < 3)      text_buf.push_back(CHAR_SLASH);
                else if (r < 6) text_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                else            text_buf.push_back(8'($urandom_range(0, 255)));
            end
        end
        push_text(1'b0, none);
    endtask

    task write_cfg(input logic idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[13:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Waits until every beat is taken and every verdict has come back.
    task wait_quiet();
        do @(negedge i_clk);
        while (beats_taken != beats_queued || verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int        p, r, i;
        byte       c;
        t_out_beat row_res;

        foreach (code_tally[k]) code_tally[k] = 0;

        // Directed rows: after-reset window 2000..2999.
        date_rows = '{
            '{"1/1/2000",          1'b1, ERR_OK,       1,  1,  2000},
            '{"31/12/2999",        1'b1, ERR_OK,       31, 12, 2999},
            '{"29/2/2000",         1'b1, ERR_OK,       29, 2,  2000},
            '{"29/2/2100",         1'b1, ERR_DAY,      0,  0,  0},
            '{"29/2/2004",         1'b0, ERR_OK,       0,  0,  0},
            '{"0/1/2000",          1'b1, ERR_DAY,      0,  0,  0},
            '{"32/1/2000",         1'b1, ERR_DAY,      0,  0,  0},
            '{"31/4/2000",         1'b1, ERR_DAY,      0,  0,  0},
            '{"1/0/2000",          1'b1, ERR_MONTH,    0,  0,  0},
            '{"1/13/2000",         1'b1, ERR_MONTH,    0,  0,  0},
            '{"1/1/1999",          1'b1, ERR_YEAR,     0,  0,  0},
            '{"1/1/3000",          1'b1, ERR_YEAR,     0,  0,  0},
            '{"1/1",               1'b1, ERR_MISSING,  0,  0,  0},
            '{"7",                 1'b1, ERR_MISSING,  0,  0,  0},
            '{"/",                 1'b1, ERR_MISSING,  0,  0,  0},
            '{"1/1/2000/",         1'b1, ERR_EXTRA,    0,  0,  0},
            '{"1/1/1/x9",          1'b1, ERR_EXTRA,    0,  0,  0},
            '{"//",                1'b1, ERR_EMPTY,    0,  0,  0},
            '{"1/1/",              1'b1, ERR_EMPTY,    0,  0,  0},
            '{"1\377/1/2000",      1'b1, ERR_NONDIGIT, 0,  0,  0},
            '{"#/1/2000",          1'b1, ERR_NONDIGIT, 0,  0,  0},
            '{"2147483648/1/2000", 1'b1, ERR_OVERFLOW, 0,  0,  0},
            '{"2147483647/1/2000", 1'b1, ERR_DAY,      0,  0,  0},
            '{"0031/0012/02999",   1'b0, ERR_OK,       0,  0,  0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_quiet();

            // Year window of this phase; the first keeps the reset values.
            case (p)
                0: ;
                1: begin cfg_lo = 0;    cfg_hi = 9999; end
                2: begin cfg_lo = 0;    cfg_hi = 0;    end
                3: begin cfg_lo = 9999; cfg_hi = 9999; end
                4: begin cfg_lo = 2500; cfg_hi = 2400; end
                default: begin
                    cfg_lo = $urandom_range(0, 9999);
                    cfg_hi = ($urandom_range(0, 99) < 80) ? $urandom_range(cfg_lo, 9999)
                                                          : $urandom_range(0, 9999);
                end
            endcase
            if (p != 0) begin
                write_cfg(CFG_YEAR_MIN, cfg_lo);
                write_cfg(CFG_YEAR_MAX, cfg_hi);
            end

            @(posedge i_clk);
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            endcase
            phase_chars = 0;

            if (p == 0) begin
                for (r = 0; r < NUM_ROWS; r++) begin
                    for (i = 0; i < date_rows[r].text.len(); i++) begin
                        c = date_rows[r].text[i];
                        text_buf.push_back((c == ZERO_BYTE_MARK) ? 8'h00 : c);
                    end
                    row_res             = '0;
                    row_res.error_code  = date_rows[r].code;
                    row_res.day_value   = 5'(date_rows[r].d);
                    row_res.month_value = 4'(date_rows[r].m);
                    row_res.year_value  = 14'(date_rows[r].y);
                    push_text(date_rows[r].fixed, row_res);
                end
                phase_chars = 0;
            end
            while (phase_chars < PHASE_CHARS) add_random_text();

            // Back-pressure: hold the receiver off so the block fills up.
            if (p == 0) begin
                @(negedge i_clk);
                hold_asked++;
            end
        end

        wait_quiet();
        repeat (2 * DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d verdicts from %0d character beats over %0d year windows.",
                 verdicts_checked, beats_taken, NUM_PHASES);
        $display("Codes seen: ok %0d, missing %0d, extra %0d, empty %0d, non-digit %0d, %s",
                 code_tally[ERR_OK], code_tally[ERR_MISSING], code_tally[ERR_EXTRA],
                 code_tally[ERR_EMPTY], code_tally[ERR_NONDIGIT],
                 $sformatf("overflow %0d, month %0d, year %0d, day %0d",
                           code_tally[ERR_OVERFLOW], code_tally[ERR_MONTH],
                           code_tally[ERR_YEAR], code_tally[ERR_DAY]));
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dsv_pkg.sv
sv/dsv_accum.sv
sv/dsv_judge.sv
sv/date_string_validator.sv
tb/date_string_validator_tb.sv
